// ===== rtl/core/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared widths, item kinds and controller/datapath handshake types for the
// sorted table binary search unit.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int KIND_W  = 1;
  localparam int POS_W   = 10;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 11;
  localparam int PROBE_W = 4;

  localparam logic [KIND_W-1:0] KIND_WRITE  = 1'b0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 1'b1;

  typedef struct packed {
    logic write;
    logic start;
    logic step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic start_done;
    logic step_done;
  } sts_t;

endpackage

// ===== rtl/core/stbs_in_if.sv =====
// ----------------------------------------------------------------------------
// stbs_in_if
// Input channel: table write words and search words with valid/ready.
// ----------------------------------------------------------------------------
interface stbs_in_if;
  import stbs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [POS_W-1:0]         entry_position;
  logic signed [VAL_W-1:0]  entry_value;
  logic signed [VAL_W-1:0]  search_key;

  modport source (output valid, kind, entry_position, entry_value, search_key,
                  input ready);
  modport sink   (input valid, kind, entry_position, entry_value, search_key,
                  output ready);
endinterface

// ===== rtl/core/stbs_out_if.sv =====
// ----------------------------------------------------------------------------
// stbs_out_if
// Result channel: one search result word with valid/ready.
// ----------------------------------------------------------------------------
interface stbs_out_if;
  import stbs_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic [POS_W-1:0]   match_position;
  logic [PROBE_W-1:0] probe_count;

  modport source (output valid, found, match_position, probe_count,
                  input ready);
  modport sink   (input valid, found, match_position, probe_count,
                  output ready);
endinterface

// ===== rtl/core/stbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// stbs_ctrl
// Controller: accepts words, sequences the search probes and hands the
// finished result to the output register.
// ----------------------------------------------------------------------------
module stbs_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [stbs_pkg::KIND_W-1:0]  in_kind,
  output logic                         in_ready,
  input  logic                         out_ready,
  output logic                         out_valid,
  output stbs_pkg::cmd_t               cmd,
  input  stbs_pkg::sts_t               sts
);
  import stbs_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_HOLD   = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_SEARCH) begin
            cmd.start = 1'b1;
            state_nxt = sts.start_done ? ST_HOLD : ST_SEARCH;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (sts.step_done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/stbs_dp.sv =====
// ----------------------------------------------------------------------------
// stbs_dp
// Datapath: table memory, entry count register, search range registers,
// probe compare and the result registers.
// ----------------------------------------------------------------------------
module stbs_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [stbs_pkg::CNT_W-1:0]        cfg_wdata,
  input  logic [stbs_pkg::POS_W-1:0]        in_entry_position,
  input  logic signed [stbs_pkg::VAL_W-1:0] in_entry_value,
  input  logic signed [stbs_pkg::VAL_W-1:0] in_search_key,
  input  stbs_pkg::cmd_t                    cmd,
  output stbs_pkg::sts_t                    sts,
  output logic                              out_found,
  output logic [stbs_pkg::POS_W-1:0]        out_match_position,
  output logic [stbs_pkg::PROBE_W-1:0]      out_probe_count
);
  import stbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int BW = AW + 1;
  localparam int SW = AW + 2;
  localparam logic [31:0] DEPTH_U = 32'(TABLE_DEPTH);

  logic signed [VAL_W-1:0] mem [TABLE_DEPTH];

  logic [CNT_W-1:0]        cnt_r;
  logic signed [VAL_W-1:0] rd_data_r;
  logic signed [VAL_W-1:0] key_r, key_nxt;
  logic [BW-1:0]           first_r, first_nxt;
  logic [BW-1:0]           lastp_r, lastp_nxt;
  logic [AW-1:0]           mid_r, mid_nxt;
  logic [PROBE_W-1:0]      probes_r, probes_nxt;
  logic                    pend_found_r, pend_found_nxt;
  logic [AW-1:0]           pend_pos_r, pend_pos_nxt;
  logic [PROBE_W-1:0]      pend_probes_r, pend_probes_nxt;
  logic                    out_found_r;
  logic [POS_W-1:0]        out_pos_r;
  logic [PROBE_W-1:0]      out_probes_r;

  logic [BW-1:0]      cnt_sat;
  logic [SW-1:0]      start_sum;
  logic [AW-1:0]      start_mid;
  logic               hit;
  logic               go_low;
  logic [BW-1:0]      step_first;
  logic [BW-1:0]      step_lastp;
  logic [PROBE_W-1:0] step_probes;
  logic               step_empty;
  logic [SW-1:0]      step_sum;
  logic [AW-1:0]      step_mid;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;

  assign cnt_sat   = (32'(cnt_r) > DEPTH_U) ? BW'(TABLE_DEPTH) : BW'(cnt_r);
  assign start_sum = SW'(cnt_sat) - SW'(1);
  assign start_mid = AW'(start_sum >> 1);

  assign hit         = (rd_data_r == key_r);
  assign go_low      = (key_r < rd_data_r);
  assign step_first  = go_low ? first_r : (BW'(mid_r) + BW'(1));
  assign step_lastp  = go_low ? BW'(mid_r) : lastp_r;
  assign step_probes = probes_r + PROBE_W'(1);
  assign step_empty  = (step_first >= step_lastp);
  assign step_sum    = SW'(step_first) + SW'(step_lastp) - SW'(1);
  assign step_mid    = AW'(step_sum >> 1);

  assign sts.start_done = (cnt_sat == '0);
  assign sts.step_done  = hit || step_empty;

  assign rd_addr = cmd.start ? start_mid : step_mid;
  assign wr_en   = cmd.write && (32'(in_entry_position) < DEPTH_U);
  assign wr_addr = AW'(in_entry_position);

  always_comb begin
    key_nxt         = key_r;
    first_nxt       = first_r;
    lastp_nxt       = lastp_r;
    mid_nxt         = mid_r;
    probes_nxt      = probes_r;
    pend_found_nxt  = pend_found_r;
    pend_pos_nxt    = pend_pos_r;
    pend_probes_nxt = pend_probes_r;
    if (cmd.start) begin
      key_nxt         = in_search_key;
      first_nxt       = '0;
      lastp_nxt       = cnt_sat;
      mid_nxt         = start_mid;
      probes_nxt      = PROBE_W'(1);
      pend_found_nxt  = 1'b0;
      pend_pos_nxt    = '0;
      pend_probes_nxt = PROBE_W'(1);
    end else if (cmd.step) begin
      if (hit) begin
        pend_found_nxt  = 1'b1;
        pend_pos_nxt    = mid_r;
        pend_probes_nxt = probes_r;
      end else begin
        first_nxt       = step_first;
        lastp_nxt       = step_lastp;
        mid_nxt         = step_mid;
        probes_nxt      = step_probes;
        pend_found_nxt  = 1'b0;
        pend_pos_nxt    = '0;
        pend_probes_nxt = step_probes;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_entry_value;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cfg_we) begin
      cnt_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    key_r         <= key_nxt;
    first_r       <= first_nxt;
    lastp_r       <= lastp_nxt;
    mid_r         <= mid_nxt;
    probes_r      <= probes_nxt;
    pend_found_r  <= pend_found_nxt;
    pend_pos_r    <= pend_pos_nxt;
    pend_probes_r <= pend_probes_nxt;
    if (cmd.publish) begin
      out_found_r  <= pend_found_r;
      out_pos_r    <= POS_W'(pend_pos_r);
      out_probes_r <= pend_probes_r;
    end
  end

  assign out_found          = out_found_r;
  assign out_match_position = out_pos_r;
  assign out_probe_count    = out_probes_r;

endmodule

// ===== rtl/core/sorted_table_binary_search_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search_unit
// A write word is written to the table as it is accepted. A search has an
// accept step, a sequence of table probes (one synchronous memory read each,
// none for an empty table, up to log2(TABLE_DEPTH)+1), and a load of the
// output register, which waits while the previous result is not yet taken.
// One word is in work at a time. Reset (synchronous, active low) clears the
// entry count and control; table contents are undefined.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [stbs_pkg::CNT_W-1:0] cfg_wdata,
  stbs_in_if.sink                    in_ch,
  stbs_out_if.source                 out_ch
);
  import stbs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_entry_position  (in_ch.entry_position),
    .in_entry_value     (in_ch.entry_value),
    .in_search_key      (in_ch.search_key),
    .cmd                (cmd),
    .sts                (sts),
    .out_found          (out_ch.found),
    .out_match_position (out_ch.match_position),
    .out_probe_count    (out_ch.probe_count)
  );

endmodule
